// ----- rtl/ldg_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ldg_pkg: shared constants and types of the line dot generator
// Holds the command kinds, the step direction codes, the color width and the
// status bundle that each queue reports.
// -----------------------------------------------------------------------------
package ldg_pkg;

	// Command kinds carried from the front part to the back part.
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	// Step direction codes for one axis.
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_POS  = 2'd1;
	localparam logic [1:0] DIR_NEG  = 2'd3;

	// Width of the pen color.
	localparam int COLOR_BITS = 16;

	// Status flags of a queue.
	typedef struct packed {
		logic full;
		logic empty;
	} ldg_q_stat_t;

endpackage
`default_nettype wire

// ----- rtl/ldg_queue.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ldg_queue: two-entry first-in first-out queue
// Decouples a producer from a consumer so each side can stall on its own; a
// push and a pop in the same cycle keep one transaction per cycle unless full.
// -----------------------------------------------------------------------------
module ldg_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              pop,
	output logic [WIDTH-1:0]       rd_data,
	output ldg_pkg::ldg_q_stat_t   stat
);
	import ldg_pkg::*;

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	// Status and handshake qualification.
	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_data    = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ldg_front.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ldg_front: input classification for the line dot generator
// Turns an incoming transaction into a command word: for a start it forms the
// absolute deltas, the step directions and the span of the line.
// -----------------------------------------------------------------------------
module ldg_front #(
	parameter int COORD_BITS = 10,
	parameter int CMD_W      = 1 + 5 * COORD_BITS + 4 + 16
) (
	input  wire logic                         kind,
	input  wire logic [COORD_BITS-1:0]        start_col,
	input  wire logic [COORD_BITS-1:0]        start_row,
	input  wire logic [COORD_BITS-1:0]        end_col,
	input  wire logic [COORD_BITS-1:0]        end_row,
	input  wire logic [ldg_pkg::COLOR_BITS-1:0] pen_color,
	output logic [CMD_W-1:0]                  cmd
);
	import ldg_pkg::*;

	logic [COORD_BITS-1:0] abs_dcol;
	logic [COORD_BITS-1:0] abs_drow;
	logic [COORD_BITS-1:0] span;
	logic [1:0]            dir_col;
	logic [1:0]            dir_row;

	// Column delta and direction.
	always_comb begin
		priority if (end_col > start_col) begin
			abs_dcol = end_col - start_col;
			dir_col  = DIR_POS;
		end else if (end_col < start_col) begin
			abs_dcol = start_col - end_col;
			dir_col  = DIR_NEG;
		end else begin
			abs_dcol = '0;
			dir_col  = DIR_NONE;
		end
	end

	// Row delta and direction.
	always_comb begin
		priority if (end_row > start_row) begin
			abs_drow = end_row - start_row;
			dir_row  = DIR_POS;
		end else if (end_row < start_row) begin
			abs_drow = start_row - end_row;
			dir_row  = DIR_NEG;
		end else begin
			abs_drow = '0;
			dir_row  = DIR_NONE;
		end
	end

	// The span is the larger of the two deltas.
	assign span = (abs_dcol > abs_drow) ? abs_dcol : abs_drow;

	// Command word, unpacked in the same order by the back part.
	assign cmd = {kind, start_col, start_row, abs_dcol, abs_drow, span,
		dir_col, dir_row, pen_color};

endmodule
`default_nettype wire

// ----- rtl/ldg_back.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ldg_back: line stepping engine of the line dot generator
// Holds the state of the running line, takes one command a cycle while the
// result queue has room, and pushes the resulting dot into the result queue.
// -----------------------------------------------------------------------------
module ldg_back #(
	parameter int COORD_BITS = 10,
	parameter int CMD_W      = 1 + 5 * COORD_BITS + 4 + 16,
	parameter int DOT_W      = 2 * COORD_BITS + 16 + 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [CMD_W-1:0]    cmd,
	input  wire ldg_pkg::ldg_q_stat_t cmd_stat,
	output logic                     cmd_pop,
	input  wire ldg_pkg::ldg_q_stat_t dot_stat,
	output logic                     dot_push,
	output logic [DOT_W-1:0]         dot
);
	import ldg_pkg::*;

	localparam int EB = COORD_BITS + 1;

	// Unpacked command fields.
	logic                  c_kind;
	logic [COORD_BITS-1:0] c_col;
	logic [COORD_BITS-1:0] c_row;
	logic [COORD_BITS-1:0] c_dcol;
	logic [COORD_BITS-1:0] c_drow;
	logic [COORD_BITS-1:0] c_span;
	logic [1:0]            c_dir_col;
	logic [1:0]            c_dir_row;
	logic [COLOR_BITS-1:0] c_color;

	// Line state.
	logic [COORD_BITS-1:0] cur_col_q;
	logic [COORD_BITS-1:0] cur_row_q;
	logic [EB-1:0]         err_col_q;
	logic [EB-1:0]         err_row_q;
	logic [COORD_BITS-1:0] abs_dcol_q;
	logic [COORD_BITS-1:0] abs_drow_q;
	logic [1:0]            dir_col_q;
	logic [1:0]            dir_row_q;
	logic [COORD_BITS-1:0] span_q;
	logic [COORD_BITS-1:0] steps_done_q;
	logic [COLOR_BITS-1:0] line_color_q;
	logic                  active_q;

	// Step results.
	logic                  fire;
	logic [EB-1:0]         ec_sum;
	logic [EB-1:0]         er_sum;
	logic                  col_move;
	logic                  row_move;
	logic [EB-1:0]         ec_next;
	logic [EB-1:0]         er_next;
	logic [COORD_BITS-1:0] col_next;
	logic [COORD_BITS-1:0] row_next;
	logic [COORD_BITS-1:0] steps_next;
	logic                  step_last;

	assign {c_kind, c_col, c_row, c_dcol, c_drow, c_span, c_dir_col, c_dir_row,
		c_color} = cmd;

	// A command is taken whenever one waits and the result queue has room.
	assign fire    = !cmd_stat.empty && !dot_stat.full;
	assign cmd_pop = fire;

	// Error accumulation and coordinate moves of one step.
	assign ec_sum   = err_col_q + {1'b0, abs_dcol_q};
	assign er_sum   = err_row_q + {1'b0, abs_drow_q};
	assign col_move = (ec_sum > {1'b0, span_q});
	assign row_move = (er_sum > {1'b0, span_q});
	assign ec_next  = col_move ? (ec_sum - {1'b0, span_q}) : ec_sum;
	assign er_next  = row_move ? (er_sum - {1'b0, span_q}) : er_sum;

	always_comb begin
		col_next = cur_col_q;
		if (col_move) begin
			unique case (dir_col_q)
				DIR_POS: col_next = cur_col_q + COORD_BITS'(1);
				DIR_NEG: col_next = cur_col_q - COORD_BITS'(1);
				default: col_next = cur_col_q;
			endcase
		end
	end

	always_comb begin
		row_next = cur_row_q;
		if (row_move) begin
			unique case (dir_row_q)
				DIR_POS: row_next = cur_row_q + COORD_BITS'(1);
				DIR_NEG: row_next = cur_row_q - COORD_BITS'(1);
				default: row_next = cur_row_q;
			endcase
		end
	end

	assign steps_next = steps_done_q + COORD_BITS'(1);
	assign step_last  = (steps_next == span_q);

	// Result dot: the start point for a start, the new point for a step.
	always_comb begin
		if (c_kind == KIND_START) begin
			dot_push = fire;
			dot      = {c_col, c_row, c_color, (c_span == '0)};
		end else begin
			dot_push = fire && active_q;
			dot      = {col_next, row_next, line_color_q, step_last};
		end
	end

	// State update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			err_col_q    <= '0;
			err_row_q    <= '0;
			abs_dcol_q   <= '0;
			abs_drow_q   <= '0;
			dir_col_q    <= DIR_NONE;
			dir_row_q    <= DIR_NONE;
			span_q       <= '0;
			steps_done_q <= '0;
			line_color_q <= '0;
			active_q     <= 1'b0;
		end else if (fire) begin
			if (c_kind == KIND_START) begin
				cur_col_q    <= c_col;
				cur_row_q    <= c_row;
				err_col_q    <= {1'b0, c_dcol};
				err_row_q    <= {1'b0, c_drow};
				abs_dcol_q   <= c_dcol;
				abs_drow_q   <= c_drow;
				dir_col_q    <= c_dir_col;
				dir_row_q    <= c_dir_row;
				span_q       <= c_span;
				steps_done_q <= '0;
				line_color_q <= c_color;
				active_q     <= (c_span != '0);
			end else if (active_q) begin
				cur_col_q    <= col_next;
				cur_row_q    <= row_next;
				err_col_q    <= ec_next;
				err_row_q    <= er_next;
				steps_done_q <= steps_next;
				active_q     <= !step_last;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/line_dot_generator.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// line_dot_generator: error-accumulation line rasterizer
// A start transaction loads two endpoints and a color and yields the start
// dot; each step transaction yields the next dot of the line.
//
// Input side is a queue: a transaction is taken when push is high and full is
// low. A start (kind 0) carries both endpoints and the pen color; a step
// (kind 1) asks for the next dot and gives no dot while no line is active.
// Result side is a queue too: the oldest dot stands on dot_col, dot_row,
// dot_color and last_dot while empty is low, and pop takes it.
// Throughput is one transaction per cycle in both directions while the receiver
// pops. A transaction waits in the command queue and its dot in the result
// queue. The stepping engine does one error add, compare and subtract per axis
// each cycle, which sets that rate. When the receiver stalls, the two-entry
// result queue fills, the engine holds, the two-entry command queue fills and
// full rises; nothing is lost. Reset empties both queues and leaves no line
// active.
// -----------------------------------------------------------------------------
module line_dot_generator #(
	parameter int COORD_BITS = 10
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         kind,
	input  wire logic [COORD_BITS-1:0]        start_col,
	input  wire logic [COORD_BITS-1:0]        start_row,
	input  wire logic [COORD_BITS-1:0]        end_col,
	input  wire logic [COORD_BITS-1:0]        end_row,
	input  wire logic [ldg_pkg::COLOR_BITS-1:0] pen_color,
	output logic                              empty,
	input  wire logic                         pop,
	output logic [COORD_BITS-1:0]             dot_col,
	output logic [COORD_BITS-1:0]             dot_row,
	output logic [ldg_pkg::COLOR_BITS-1:0]    dot_color,
	output logic                              last_dot
);
	import ldg_pkg::*;

	localparam int CMD_W = 1 + 5 * COORD_BITS + 4 + COLOR_BITS;
	localparam int DOT_W = 2 * COORD_BITS + COLOR_BITS + 1;

	logic [CMD_W-1:0] cmd_in;
	logic [CMD_W-1:0] cmd_out;
	ldg_q_stat_t      cmd_stat;
	logic             cmd_pop;
	logic [DOT_W-1:0] dot_in;
	logic [DOT_W-1:0] dot_out;
	ldg_q_stat_t      dot_stat;
	logic             dot_push;

	// Front part: classify the transaction and form the line parameters.
	ldg_front #(
		.COORD_BITS(COORD_BITS),
		.CMD_W     (CMD_W)
	) u_front (
		.kind     (kind),
		.start_col(start_col),
		.start_row(start_row),
		.end_col  (end_col),
		.end_row  (end_row),
		.pen_color(pen_color),
		.cmd      (cmd_in)
	);

	// Command queue between the front and back parts.
	ldg_queue #(
		.WIDTH(CMD_W)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(cmd_in),
		.pop    (cmd_pop),
		.rd_data(cmd_out),
		.stat   (cmd_stat)
	);

	// Back part: step the line and produce dots.
	ldg_back #(
		.COORD_BITS(COORD_BITS),
		.CMD_W     (CMD_W),
		.DOT_W     (DOT_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_out),
		.cmd_stat(cmd_stat),
		.cmd_pop (cmd_pop),
		.dot_stat(dot_stat),
		.dot_push(dot_push),
		.dot     (dot_in)
	);

	// Result queue toward the receiver.
	ldg_queue #(
		.WIDTH(DOT_W)
	) u_dot_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (dot_push),
		.wr_data(dot_in),
		.pop    (pop),
		.rd_data(dot_out),
		.stat   (dot_stat)
	);

	assign full  = cmd_stat.full;
	assign empty = dot_stat.empty;
	assign {dot_col, dot_row, dot_color, last_dot} = dot_out;

endmodule
`default_nettype wire

// ----- tb/line_dot_checker.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// line_dot_checker: dot predictor and scoreboard for the line dot generator
// Watches both queue interfaces. Each accepted command runs through a private
// copy of the line-stepping arithmetic, and the dot it yields is queued. Each
// popped dot is compared field by field with the oldest queued dot.
// -----------------------------------------------------------------------------
module line_dot_checker
	import ldg_pkg::*;
#(
	parameter int COORD_BITS = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic                  full,
	input  wire logic                  kind,
	input  wire logic [COORD_BITS-1:0] start_col,
	input  wire logic [COORD_BITS-1:0] start_row,
	input  wire logic [COORD_BITS-1:0] end_col,
	input  wire logic [COORD_BITS-1:0] end_row,
	input  wire logic [COLOR_BITS-1:0] pen_color,
	input  wire logic                  empty,
	input  wire logic                  pop,
	input  wire logic [COORD_BITS-1:0] dot_col,
	input  wire logic [COORD_BITS-1:0] dot_row,
	input  wire logic [COLOR_BITS-1:0] dot_color,
	input  wire logic                  last_dot,
	output int                         mismatches,
	output int                         waiting,
	output int                         dots_seen
);

	typedef struct packed {
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
	} dot_t;

	// Private copy of the line state.
	logic [COORD_BITS-1:0] pos_col, pos_row;
	logic [COORD_BITS:0]   acc_col, acc_row;
	logic [COORD_BITS-1:0] delta_col, delta_row;
	logic [1:0]            step_col, step_row;
	logic [COORD_BITS-1:0] major_len, dots_drawn;
	logic [COLOR_BITS-1:0] ink;
	logic                  drawing;

	dot_t dots_due[$];
	int   bad_count;
	int   seen_count;

	// Moves one coordinate a unit in its direction, wrapping at the width.
	function automatic logic [COORD_BITS-1:0] nudge(input logic [COORD_BITS-1:0] c,
			input logic [1:0] dir);
		if (dir == DIR_POS)
			return c + 1'b1;
		if (dir == DIR_NEG)
			return c - 1'b1;
		return c;
	endfunction

	// A start command: form deltas, directions and span, and queue the first dot.
	task automatic begin_line(input logic [COORD_BITS-1:0] sc, input logic [COORD_BITS-1:0] sr,
			input logic [COORD_BITS-1:0] ec, input logic [COORD_BITS-1:0] er,
			input logic [COLOR_BITS-1:0] color);
		if (ec > sc) begin
			delta_col = ec - sc;
			step_col = DIR_POS;
		end else if (ec < sc) begin
			delta_col = sc - ec;
			step_col = DIR_NEG;
		end else begin
			delta_col = '0;
			step_col = DIR_NONE;
		end
		if (er > sr) begin
			delta_row = er - sr;
			step_row = DIR_POS;
		end else if (er < sr) begin
			delta_row = sr - er;
			step_row = DIR_NEG;
		end else begin
			delta_row = '0;
			step_row = DIR_NONE;
		end
		major_len = (delta_col > delta_row) ? delta_col : delta_row;
		acc_col = {1'b0, delta_col};
		acc_row = {1'b0, delta_row};
		pos_col = sc;
		pos_row = sr;
		ink = color;
		dots_drawn = '0;
		drawing = (major_len != '0);
		dots_due.push_back('{col: pos_col, row: pos_row, color: ink,
			last: (major_len == '0)});
	endtask

	// A step command: accumulate errors, move where an error passes the span.
	task automatic advance_line();
		logic at_end;
		if (!drawing)
			return;
		acc_col = acc_col + {1'b0, delta_col};
		acc_row = acc_row + {1'b0, delta_row};
		if (acc_col > {1'b0, major_len}) begin
			acc_col = acc_col - {1'b0, major_len};
			pos_col = nudge(pos_col, step_col);
		end
		if (acc_row > {1'b0, major_len}) begin
			acc_row = acc_row - {1'b0, major_len};
			pos_row = nudge(pos_row, step_row);
		end
		dots_drawn = dots_drawn + 1'b1;
		at_end = (dots_drawn == major_len);
		if (at_end)
			drawing = 1'b0;
		dots_due.push_back('{col: pos_col, row: pos_row, color: ink, last: at_end});
	endtask

	task automatic report_field(input string name, input int want, input int got);
		bad_count++;
		if (bad_count <= 40)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
	endtask

	// A popped dot: compare with the oldest predicted dot.
	task automatic check_dot();
		dot_t want;
		seen_count++;
		if (dots_due.size() == 0) begin
			bad_count++;
			if (bad_count <= 40)
				$display("%0t: dot (%0d,%0d) popped, expected no dot, actual one",
					$time, dot_col, dot_row);
			return;
		end
		want = dots_due.pop_front();
		if (dot_col !== want.col)
			report_field("dot_col", want.col, dot_col);
		if (dot_row !== want.row)
			report_field("dot_row", want.row, dot_row);
		if (dot_color !== want.color)
			report_field("dot_color", want.color, dot_color);
		if (last_dot !== want.last)
			report_field("last_dot", want.last, last_dot);
	endtask

	// Sample both interfaces at every rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_col = '0;
			pos_row = '0;
			acc_col = '0;
			acc_row = '0;
			delta_col = '0;
			delta_row = '0;
			step_col = DIR_NONE;
			step_row = DIR_NONE;
			major_len = '0;
			dots_drawn = '0;
			ink = '0;
			drawing = 1'b0;
			dots_due.delete();
			bad_count = 0;
			seen_count = 0;
			mismatches <= 0;
			waiting <= 0;
			dots_seen <= 0;
		end else begin
			if (push && !full) begin
				if (kind == KIND_START)
					begin_line(start_col, start_row, end_col, end_row, pen_color);
				else
					advance_line();
			end
			if (pop && !empty)
				check_dot();
			mismatches <= bad_count;
			waiting <= dots_due.size();
			dots_seen <= seen_count;
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench: top level for the line dot generator
// Drives start and step transactions with random gaps and pops dots with
// random stalls. A directed opening covers idle steps, zero-length lines,
// every direction and abandoned lines; random lines follow. The checker
// beside the block predicts and compares every dot.
// -----------------------------------------------------------------------------
module testbench;
	import ldg_pkg::*;

	localparam int COORD_BITS = 10;
	localparam int COORD_MAX = (1 << COORD_BITS) - 1;
	localparam int COLOR_MAX = (1 << COLOR_BITS) - 1;
	localparam int LINE_ITEMS = 750;
	localparam int CALM_ITEMS = 650;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic                  kind;
	logic [COORD_BITS-1:0] start_col;
	logic [COORD_BITS-1:0] start_row;
	logic [COORD_BITS-1:0] end_col;
	logic [COORD_BITS-1:0] end_row;
	logic [COLOR_BITS-1:0] pen_color;
	logic                  empty;
	logic                  pop;
	logic [COORD_BITS-1:0] dot_col;
	logic [COORD_BITS-1:0] dot_row;
	logic [COLOR_BITS-1:0] dot_color;
	logic                  last_dot;

	int mismatches, waiting, dots_seen;
	int n_items, n_starts, n_idle_steps;
	int gap_pct, stall_pct;
	bit calm;

	line_dot_generator #(.COORD_BITS(COORD_BITS)) i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.start_col(start_col), .start_row(start_row), .end_col(end_col),
		.end_row(end_row), .pen_color(pen_color), .empty(empty), .pop(pop),
		.dot_col(dot_col), .dot_row(dot_row), .dot_color(dot_color),
		.last_dot(last_dot)
	);

	line_dot_checker #(.COORD_BITS(COORD_BITS)) i_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.start_col(start_col), .start_row(start_row), .end_col(end_col),
		.end_row(end_row), .pen_color(pen_color), .empty(empty), .pop(pop),
		.dot_col(dot_col), .dot_row(dot_row), .dot_color(dot_color),
		.last_dot(last_dot), .mismatches(mismatches), .waiting(waiting),
		.dots_seen(dots_seen)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#1_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	function automatic int clamp_coord(input int v);
		if (v < 0)
			return 0;
		if (v > COORD_MAX)
			return COORD_MAX;
		return v;
	endfunction

	// A coordinate at or next to either edge of the range.
	function automatic int edge_coord();
		if ($urandom_range(0, 1))
			return $urandom_range(0, 1);
		return COORD_MAX - $urandom_range(0, 1);
	endfunction

	// Presents one transaction, holds it until taken, then maybe goes idle.
	task automatic send_item(input logic k, input int sc, input int sr, input int ec,
			input int er, input int color);
		push <= 1'b1;
		kind <= k;
		start_col <= sc[COORD_BITS-1:0];
		start_row <= sr[COORD_BITS-1:0];
		end_col <= ec[COORD_BITS-1:0];
		end_row <= er[COORD_BITS-1:0];
		pen_color <= color[COLOR_BITS-1:0];
		do
			@(posedge clk);
		while (full);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// One start transaction followed by a number of step transactions whose
	// unused fields carry noise. Steps past the span find no active line.
	task automatic draw_line(input int sc, input int sr, input int ec, input int er,
			input int color, input int n_steps);
		int span;
		span = (ec > sc) ? ec - sc : sc - ec;
		if (((er > sr) ? er - sr : sr - er) > span)
			span = (er > sr) ? er - sr : sr - er;
		send_item(KIND_START, sc, sr, ec, er, color);
		n_starts++;
		n_items++;
		for (int i = 0; i < n_steps; i++) begin
			send_item(KIND_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
				$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
				$urandom_range(0, COLOR_MAX));
			if (i < span)
				n_items++;
			else
				n_idle_steps++;
		end
		calm = (n_items >= CALM_ITEMS);
	endtask

	// Result side: pop with bursts of stalls whose density changes over time.
	initial begin
		int stall_left;
		int mode_cycles;
		stall_left = 0;
		mode_cycles = 0;
		stall_pct = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (mode_cycles == 0) begin
				mode_cycles = 128;
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 10;
					2: stall_pct = 35;
					default: stall_pct = 70;
				endcase
			end
			mode_cycles--;
			if (!arst_n || calm) begin
				stall_left = 0;
				pop <= arst_n;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 5) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int sc, sr, ec, er, span, n_steps, r;
		push <= 1'b0;
		kind <= KIND_START;
		start_col <= '0;
		start_row <= '0;
		end_col <= '0;
		end_row <= '0;
		pen_color <= '0;
		arst_n <= 1'b0;
		n_items = 0;
		n_starts = 0;
		n_idle_steps = 0;
		gap_pct = 0;
		calm = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: step with no line ever drawn, zero-length line and a
		// step after it, shallow and steep lines both ways, a line abandoned by a
		// new start, and a horizontal line stepped to its end.
		gap_pct = 20;
		send_item(KIND_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COLOR_MAX);
		n_idle_steps++;
		draw_line(5, 5, 5, 5, 'hFFFF, 1);
		draw_line(0, 0, 3, 1, 'h0000, 3);
		draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 5, 'hA5A5, 5);
		draw_line(0, COORD_MAX, COORD_MAX, 0, 'h5A5A, 2);
		draw_line(COORD_MAX, 0, COORD_MAX, 2, 'h0F0F, 2);
		draw_line(7, 9, 2, 9, 'hF0F0, 5);

		// Random lines: mostly short ones drawn to the end, some axis-aligned or
		// zero-length, some long ones across the range that are usually cut short.
		while (n_items < LINE_ITEMS) begin
			case ($urandom_range(0, 3))
				0: gap_pct = 0;
				1: gap_pct = 10;
				2: gap_pct = 30;
				default: gap_pct = 60;
			endcase
			r = $urandom_range(0, 99);
			sc = $urandom_range(0, COORD_MAX);
			sr = $urandom_range(0, COORD_MAX);
			if (r < 65) begin
				ec = clamp_coord(sc + int'($urandom_range(0, 32)) - 16);
				er = clamp_coord(sr + int'($urandom_range(0, 32)) - 16);
			end else if (r < 78) begin
				ec = sc;
				er = sr;
				if ($urandom_range(0, 1))
					ec = clamp_coord(sc + int'($urandom_range(0, 40)) - 20);
				else
					er = clamp_coord(sr + int'($urandom_range(0, 40)) - 20);
			end else if (r < 90) begin
				sc = edge_coord();
				sr = edge_coord();
				ec = edge_coord();
				er = edge_coord();
			end else begin
				ec = $urandom_range(0, COORD_MAX);
				er = $urandom_range(0, COORD_MAX);
			end
			span = (ec > sc) ? ec - sc : sc - ec;
			if (((er > sr) ? er - sr : sr - er) > span)
				span = (er > sr) ? er - sr : sr - er;
			r = $urandom_range(0, 99);
			if (span > 48)
				n_steps = ($urandom_range(0, 29) == 0) ? span : $urandom_range(1, 40);
			else if (r < 75 || span == 0)
				n_steps = span;
			else if (r < 90)
				n_steps = $urandom_range(0, span - 1);
			else
				n_steps = span + $urandom_range(1, 3);
			draw_line(sc, sr, ec, er, $urandom_range(0, COLOR_MAX), n_steps);
		end
		push <= 1'b0;

		// Drain: wait for every predicted dot, and then on for any stray dots.
		for (int w = 0; w < 5000 && waiting != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d lines and %0d drawing steps, plus %0d steps with no line.",
			n_starts, n_items - n_starts, n_idle_steps);
		$display("Checked %0d dots, %0d field mismatches, %0d dots never seen.",
			dots_seen, mismatches, waiting);
		if (mismatches == 0 && waiting == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
